/* hdl/sepw_pkg.sv */
// Shared types and constants of the SPI EEPROM page write sequencer.
package sepw_pkg;

  // One result beat, without the last flag (set when the beat leaves).
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] spi_byte;
    logic       deselect_after;
    logic [7:0] host_byte;
  } res_t;

  // Most beats one item gives: a write-enable frame header of four bytes.
  localparam int JobSlots = 4;
  localparam int SlotW    = 2;

  // Work for the back end: up to four beats, sent from ent[0] up to ent[last_idx].
  typedef struct packed {
    logic [SlotW-1:0]             last_idx;
    res_t [JobSlots-1:0]          ent;
  } job_t;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

endpackage

/* hdl/sepw_if.sv */
// Valid/ready channel interfaces for requests and result beats.
interface sepw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] address;
  logic [16:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, output cmd, output address, output length,
                  output data_byte, input ready);
  modport sink   (input valid, input cmd, input address, input length,
                  input data_byte, output ready);
endinterface

interface sepw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] spi_byte;
  logic       deselect_after;
  logic [7:0] host_byte;
  logic       last;

  modport source (output valid, output kind, output spi_byte, output deselect_after,
                  output host_byte, output last, input ready);
  modport sink   (input valid, input kind, input spi_byte, input deselect_after,
                  input host_byte, input last, output ready);
endinterface

/* hdl/sepw_front.sv */
// Front end: takes requests, keeps the sequencer state and queues the beats of each item.
module sepw_front #(
  parameter int PAGE_BYTES    = 128,
  parameter int STORAGE_BYTES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [15:0]      cfg_wdata,
  sepw_in_if.sink          request,
  input  logic             queue_full,
  output logic             push,
  output sepw_pkg::job_t   job
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WDATA = 2'd1;
  localparam logic [1:0] PH_POLL  = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  localparam logic [2:0] CMD_WRITE_REQ = 3'd0;
  localparam logic [2:0] CMD_HOST_BYTE = 3'd1;
  localparam logic [2:0] CMD_READ_REQ  = 3'd2;
  localparam logic [2:0] CMD_DEV_BYTE  = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;

  localparam logic [2:0] KIND_SEND    = 3'd0;
  localparam logic [2:0] KIND_SLOT    = 3'd1;
  localparam logic [2:0] KIND_HOST    = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_RANGE   = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT = 3'd5;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] SR_WIP   = 8'h01;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5;

  // address % PAGE_BYTES by reciprocal: q = (address * DIV_MUL) >> DIV_SHIFT, exact on 16 bits
  localparam int          OFF_W     = $clog2(PAGE_BYTES);
  localparam int          DIV_SHIFT = 16 + OFF_W;
  localparam logic [16:0] DIV_MUL   = 17'((2 ** DIV_SHIFT + PAGE_BYTES - 1) / PAGE_BYTES);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAGE_BYTES - 1);

  logic [1:0]       phase, phase_next;
  logic [15:0]      cur_addr, cur_addr_next;
  logic [16:0]      remaining, remaining_next;
  logic [OFF_W-1:0] page_off, page_off_next;
  logic [15:0]      tick_cnt, tick_cnt_next;
  logic             hdr_pend, hdr_pend_next;
  logic [15:0]      poll_timeout;

  logic             off_pending;
  logic             off_start;
  logic [15:0]      mod_addr;
  logic [32:0]      mod_prod;
  logic [15:0]      mod_quo;

  logic             fire;
  logic             want_push;
  logic [17:0]      span;
  logic             range_bad;
  logic             wip;
  logic [16:0]      rem_dec;

  function automatic sepw_pkg::res_t mk(input logic [2:0] k, input logic [7:0] sb,
                                        input logic ds, input logic [7:0] hb);
    sepw_pkg::res_t r;
    r.kind           = k;
    r.spi_byte       = sb;
    r.deselect_after = ds;
    r.host_byte      = hb;
    return r;
  endfunction

  function automatic sepw_pkg::job_t chunk_job(input logic [15:0] a);
    sepw_pkg::job_t j;
    j          = '0;
    j.ent[0]   = mk(KIND_SEND, OP_WREN, 1'b1, 8'h00);
    j.ent[1]   = mk(KIND_SEND, OP_WRITE, 1'b0, 8'h00);
    j.ent[2]   = mk(KIND_SEND, a[15:8], 1'b0, 8'h00);
    j.ent[3]   = mk(KIND_SEND, a[7:0], 1'b0, 8'h00);
    j.last_idx = sepw_pkg::SlotW'(3);
    return j;
  endfunction

  function automatic sepw_pkg::job_t single_job(input sepw_pkg::res_t r);
    sepw_pkg::job_t j;
    j          = '0;
    j.ent[0]   = r;
    j.last_idx = sepw_pkg::SlotW'(0);
    return j;
  endfunction

  assign fire          = request.valid && request.ready;
  assign request.ready = !queue_full && !off_pending;
  assign push          = fire && want_push;
  assign span          = {2'b00, request.address} + {1'b0, request.length};
  assign range_bad     = span > 18'(STORAGE_BYTES);
  assign wip           = (request.data_byte & SR_WIP) != 8'h00;
  assign rem_dec       = remaining - 17'd1;
  assign mod_quo       = 16'(mod_prod >> DIV_SHIFT);

  always_comb begin
    phase_next     = phase;
    cur_addr_next  = cur_addr;
    remaining_next = remaining;
    page_off_next  = page_off;
    tick_cnt_next  = tick_cnt;
    hdr_pend_next  = hdr_pend;
    off_start      = 1'b0;
    want_push      = 1'b0;
    job            = '0;
    unique case (request.cmd)
      CMD_WRITE_REQ: begin
        if (phase == PH_IDLE) begin
          want_push = 1'b1;
          if (range_bad) begin
            job = single_job(mk(KIND_RANGE, 8'h00, 1'b0, 8'h00));
          end else if (request.length == 17'd0) begin
            job = single_job(mk(KIND_DONE, 8'h00, 1'b0, 8'h00));
          end else begin
            job            = chunk_job(request.address);
            cur_addr_next  = request.address;
            remaining_next = request.length;
            phase_next     = PH_WDATA;
            off_start      = 1'b1;
          end
        end
      end
      CMD_HOST_BYTE: begin
        if (phase == PH_WDATA) begin
          want_push      = 1'b1;
          cur_addr_next  = cur_addr + 16'd1;
          remaining_next = rem_dec;
          page_off_next  = (page_off == OFF_LAST) ? '0 : page_off + OFF_W'(1);
          // chunk ends at the page boundary or on the request's last byte
          if (page_off == OFF_LAST || remaining == 17'd1) begin
            job.ent[0]    = mk(KIND_SEND, request.data_byte, 1'b1, 8'h00);
            job.ent[1]    = mk(KIND_SEND, OP_RDSR, 1'b0, 8'h00);
            job.ent[2]    = mk(KIND_SLOT, 8'h00, 1'b1, 8'h00);
            job.last_idx  = sepw_pkg::SlotW'(2);
            phase_next    = PH_POLL;
            tick_cnt_next = 16'd0;
            hdr_pend_next = 1'b1;
          end else begin
            job = single_job(mk(KIND_SEND, request.data_byte, 1'b0, 8'h00));
          end
        end
      end
      CMD_READ_REQ: begin
        if (phase == PH_IDLE) begin
          want_push = 1'b1;
          if (range_bad) begin
            job = single_job(mk(KIND_RANGE, 8'h00, 1'b0, 8'h00));
          end else begin
            job.ent[0]   = mk(KIND_SEND, OP_READ, 1'b0, 8'h00);
            job.ent[1]   = mk(KIND_SEND, request.address[15:8], 1'b0, 8'h00);
            job.last_idx = sepw_pkg::SlotW'(3);
            if (request.length == 17'd0) begin
              job.ent[2] = mk(KIND_SEND, request.address[7:0], 1'b1, 8'h00);
              job.ent[3] = mk(KIND_DONE, 8'h00, 1'b0, 8'h00);
            end else begin
              job.ent[2]     = mk(KIND_SEND, request.address[7:0], 1'b0, 8'h00);
              job.ent[3]     = mk(KIND_SLOT, 8'h00, request.length == 17'd1, 8'h00);
              cur_addr_next  = request.address;
              remaining_next = request.length;
              hdr_pend_next  = 1'b1;
              phase_next     = PH_READ;
            end
          end
        end
      end
      CMD_DEV_BYTE: begin
        if (hdr_pend) begin
          if (phase == PH_POLL) begin
            want_push     = 1'b1;
            hdr_pend_next = 1'b0;
            if (!wip) begin
              if (remaining == 17'd0) begin
                phase_next = PH_IDLE;
                job        = single_job(mk(KIND_DONE, 8'h00, 1'b0, 8'h00));
              end else begin
                // previous chunk ended on a boundary, so page_off is already zero
                job        = chunk_job(cur_addr);
                phase_next = PH_WDATA;
              end
            end else if (tick_cnt >= poll_timeout) begin
              phase_next     = PH_IDLE;
              remaining_next = 17'd0;
              job            = single_job(mk(KIND_TIMEOUT, 8'h00, 1'b0, 8'h00));
            end else begin
              job.ent[0]    = mk(KIND_SEND, OP_RDSR, 1'b0, 8'h00);
              job.ent[1]    = mk(KIND_SLOT, 8'h00, 1'b1, 8'h00);
              job.last_idx  = sepw_pkg::SlotW'(1);
              hdr_pend_next = 1'b1;
            end
          end else if (phase == PH_READ) begin
            want_push      = 1'b1;
            job.ent[0]     = mk(KIND_HOST, 8'h00, 1'b0, request.data_byte);
            job.last_idx   = sepw_pkg::SlotW'(1);
            cur_addr_next  = cur_addr + 16'd1;
            remaining_next = rem_dec;
            if (rem_dec == 17'd0) begin
              hdr_pend_next = 1'b0;
              phase_next    = PH_IDLE;
              job.ent[1]    = mk(KIND_DONE, 8'h00, 1'b0, 8'h00);
            end else begin
              job.ent[1] = mk(KIND_SLOT, 8'h00, rem_dec == 17'd1, 8'h00);
            end
          end else begin
            hdr_pend_next = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        if (phase == PH_POLL && tick_cnt != 16'hffff) begin
          tick_cnt_next = tick_cnt + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      cur_addr     <= 16'd0;
      remaining    <= 17'd0;
      tick_cnt     <= 16'd0;
      hdr_pend     <= 1'b0;
      page_off     <= '0;
      off_pending  <= 1'b0;
      poll_timeout <= TIMEOUT_RESET;
    end else begin
      if (cfg_wen) begin
        poll_timeout <= cfg_wdata;
      end
      if (fire) begin
        phase     <= phase_next;
        cur_addr  <= cur_addr_next;
        remaining <= remaining_next;
        tick_cnt  <= tick_cnt_next;
        hdr_pend  <= hdr_pend_next;
      end
      off_pending <= fire && off_start;
      if (off_pending) begin
        page_off <= OFF_W'(mod_addr - 16'(mod_quo * 16'(PAGE_BYTES)));
      end else if (fire) begin
        page_off <= page_off_next;
      end
    end
  end

  // page offset of a new request: product registered, remainder registered in the following cycle
  always_ff @(posedge clk) begin
    if (fire && off_start) begin
      mod_addr <= request.address;
      mod_prod <= 33'(request.address) * 33'(DIV_MUL);
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_slot: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !hdr_pend)
    else $error("receive slot outstanding while idle");

  a_busy_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WDATA || phase == PH_READ) |-> remaining != 17'd0)
    else $error("data phase with no bytes left");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("item taken with job queue full");
`endif

endmodule

/* hdl/sepw_queue.sv */
// Job queue between front and back ends.
module sepw_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sepw_pkg::job_t      wr_job,
  output logic                full,
  input  logic                pop,
  output sepw_pkg::job_t      head,
  output logic                empty
);

  sepw_pkg::job_t                   slots [sepw_pkg::QueueDepth];
  logic [sepw_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [sepw_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [sepw_pkg::QueuePtrW:0]     count;

  assign full  = count == (sepw_pkg::QueuePtrW + 1)'(sepw_pkg::QueueDepth);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty job queue");
`endif

endmodule

/* hdl/sepw_back.sv */
// Back end: walks each queued job and drives the result register one beat per cycle while result.ready is high.
module sepw_back (
  input  logic                     clk,
  input  logic                     rst,
  input  sepw_pkg::job_t           head,
  input  logic                     empty,
  output logic                     pop,
  sepw_out_if.source               result
);

  logic [sepw_pkg::SlotW-1:0] sub;
  logic                       load;
  logic                       last_beat;

  assign load      = !empty && (!result.valid || result.ready);
  assign last_beat = sub == head.last_idx;
  assign pop       = load && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      sub          <= '0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        sub          <= last_beat ? '0 : sub + 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind           <= head.ent[sub].kind;
      result.spi_byte       <= head.ent[sub].spi_byte;
      result.deselect_after <= head.ent[sub].deselect_after;
      result.host_byte      <= head.ent[sub].host_byte;
      result.last           <= last_beat;
    end
  end

`ifndef ASSERT_OFF
  a_mid_job_head: assert property (@(posedge clk) disable iff (rst)
    sub != '0 |-> !empty)
    else $error("job left mid-way without its head");

  a_sub_bound: assert property (@(posedge clk) disable iff (rst)
    (sub != '0 && !empty) |-> sub <= head.last_idx)
    else $error("beat index past end of job");
`endif

endmodule

/* hdl/spi_eeprom_page_write_sequencer_core.sv */
// Top level of the SPI EEPROM page write sequencer.
//
//  channel    dir  handshake      beat payload
//  request    in   valid/ready    cmd, address, length, data_byte
//  result     out  valid/ready    kind, spi_byte, deselect_after, host_byte, last
//  cfg        in   cfg_wen        cfg_wdata -> poll timeout (ticks)
//
// An item gives 0 to 4 result beats, which leave the result register one per cycle while
// result.ready is high. A write request that starts a transfer holds request.ready low
// in the cycle after it is taken, while the page offset is worked out (multiply by
// reciprocal, then remainder).
// A four-job queue lets requests keep coming while result beats are stalled.
// Synchronous active-high reset; no clearing pass.
module spi_eeprom_page_write_sequencer_core #(
  parameter int PAGE_BYTES    = 128,
  parameter int STORAGE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  sepw_in_if.sink     request,
  sepw_out_if.source  result
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  sepw_pkg::job_t wr_job;
  sepw_pkg::job_t head;

  sepw_front #(
    .PAGE_BYTES   (PAGE_BYTES),
    .STORAGE_BYTES(STORAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .queue_full(full),
    .push      (push),
    .job       (wr_job)
  );

  sepw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_job(wr_job),
    .full  (full),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  sepw_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

endmodule

/* tb/spi_eeprom_page_write_sequencer_core_tb.sv */
// Self-checking testbench for the SPI EEPROM page write sequencer core.
`timescale 1ns / 1ps

module spi_eeprom_page_write_sequencer_core_tb;

  localparam int PAGE_BYTES    = 128;
  localparam int STORAGE_BYTES = 65536;
  localparam int HOLD_AT       = 60;   // request beats taken before the long result hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_CYCLES  = 20;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] SR_WIP   = 8'h01;

  typedef enum logic [2:0] {
    CMD_WRITE_REQ = 3'd0,
    CMD_HOST_BYTE = 3'd1,
    CMD_READ_REQ  = 3'd2,
    CMD_DEV_BYTE  = 3'd3,
    CMD_TICK      = 3'd4,
    CMD_RSVD      = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SEND    = 3'd0,
    KIND_SLOT    = 3'd1,
    KIND_HOST    = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_RANGE   = 3'd4,
    KIND_TIMEOUT = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WDATA = 2'd1,
    PH_POLL  = 2'd2,
    PH_READ  = 2'd3
  } phase_e;

  typedef struct packed {
    sepw_pkg::res_t body;
    logic           last;
  } beat_t;

  // Tracks the sequencer state and the SPI frame beats still owed by the block.
  class eeprom_frame_tracker;
    phase_e      phase;
    logic [15:0] cur_addr;
    logic [16:0] bytes_left;
    logic [7:0]  chunk_left;
    logic [15:0] poll_ticks;
    bit          slot_open;
    logic [15:0] timeout_ticks;
    beat_t       frames_due[$];
    beat_t       fresh[$];
    int unsigned beats_seen, pages, range_errs, timeouts;

    function new();
      phase         = PH_IDLE;
      cur_addr      = '0;
      bytes_left    = '0;
      chunk_left    = '0;
      poll_ticks    = '0;
      slot_open     = 0;
      timeout_ticks = 16'd5;
      beats_seen    = 0;
      pages         = 0;
      range_errs    = 0;
      timeouts      = 0;
    endfunction

    function void add_beat(logic [2:0] kind, logic [7:0] sb, logic desel, logic [7:0] hb);
      beat_t b;
      b.body.kind           = kind;
      b.body.spi_byte       = sb;
      b.body.deselect_after = desel;
      b.body.host_byte      = hb;
      b.last                = 1'b0;
      fresh.push_back(b);
    endfunction

    function void open_chunk();
      int unsigned span;
      span = PAGE_BYTES - (32'(cur_addr) % PAGE_BYTES);
      if (span > 32'(bytes_left))
        span = 32'(bytes_left);
      chunk_left = 8'(span - 1);
      add_beat(KIND_SEND, OP_WREN, 1'b1, 8'h00);
      add_beat(KIND_SEND, OP_WRITE, 1'b0, 8'h00);
      add_beat(KIND_SEND, cur_addr[15:8], 1'b0, 8'h00);
      add_beat(KIND_SEND, cur_addr[7:0], 1'b0, 8'h00);
      phase = PH_WDATA;
      pages++;
    endfunction

    function void open_poll();
      add_beat(KIND_SEND, OP_RDSR, 1'b0, 8'h00);
      add_beat(KIND_SLOT, 8'h00, 1'b1, 8'h00);
      slot_open = 1;
    endfunction

    // Returns 1 when the beat changed anything (a result or a tick in the poll phase).
    function bit take_request(logic [2:0] cmd, logic [15:0] addr, logic [16:0] len,
                              logic [7:0] db);
      bit acted;
      int unsigned reach;
      acted = 0;
      fresh.delete();
      reach = 32'(addr) + 32'(len);
      case (cmd)
        CMD_WRITE_REQ: if (phase == PH_IDLE) begin
          if (reach > STORAGE_BYTES) begin
            add_beat(KIND_RANGE, 8'h00, 1'b0, 8'h00);
            range_errs++;
          end else if (len == 0) begin
            add_beat(KIND_DONE, 8'h00, 1'b0, 8'h00);
          end else begin
            cur_addr   = addr;
            bytes_left = len;
            open_chunk();
          end
        end
        CMD_HOST_BYTE: if (phase == PH_WDATA) begin
          cur_addr++;
          bytes_left--;
          if (chunk_left == 0) begin
            add_beat(KIND_SEND, db, 1'b1, 8'h00);
            phase      = PH_POLL;
            poll_ticks = '0;
            open_poll();
          end else begin
            add_beat(KIND_SEND, db, 1'b0, 8'h00);
            chunk_left--;
          end
        end
        CMD_READ_REQ: if (phase == PH_IDLE) begin
          if (reach > STORAGE_BYTES) begin
            add_beat(KIND_RANGE, 8'h00, 1'b0, 8'h00);
            range_errs++;
          end else begin
            add_beat(KIND_SEND, OP_READ, 1'b0, 8'h00);
            add_beat(KIND_SEND, addr[15:8], 1'b0, 8'h00);
            if (len == 0) begin
              add_beat(KIND_SEND, addr[7:0], 1'b1, 8'h00);
              add_beat(KIND_DONE, 8'h00, 1'b0, 8'h00);
            end else begin
              add_beat(KIND_SEND, addr[7:0], 1'b0, 8'h00);
              add_beat(KIND_SLOT, 8'h00, len == 1, 8'h00);
              cur_addr   = addr;
              bytes_left = len;
              slot_open  = 1;
              phase      = PH_READ;
            end
          end
        end
        CMD_DEV_BYTE: if (slot_open) begin
          if (phase == PH_POLL) begin
            slot_open = 0;
            if ((db & SR_WIP) == 0) begin
              if (bytes_left == 0) begin
                phase = PH_IDLE;
                add_beat(KIND_DONE, 8'h00, 1'b0, 8'h00);
              end else begin
                open_chunk();
              end
            end else if (poll_ticks >= timeout_ticks) begin
              phase      = PH_IDLE;
              bytes_left = '0;
              add_beat(KIND_TIMEOUT, 8'h00, 1'b0, 8'h00);
              timeouts++;
            end else begin
              open_poll();
            end
          end else if (phase == PH_READ) begin
            add_beat(KIND_HOST, 8'h00, 1'b0, db);
            cur_addr++;
            bytes_left--;
            if (bytes_left == 0) begin
              slot_open = 0;
              phase     = PH_IDLE;
              add_beat(KIND_DONE, 8'h00, 1'b0, 8'h00);
            end else begin
              add_beat(KIND_SLOT, 8'h00, bytes_left == 1, 8'h00);
            end
          end else begin
            slot_open = 0;
          end
        end
        CMD_TICK: if (phase == PH_POLL) begin
          acted = 1;
          if (poll_ticks != 16'hFFFF)
            poll_ticks++;
        end
        default: ;
      endcase
      if (fresh.size() > 0) begin
        acted = 1;
        fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i])
          frames_due.push_back(fresh[i]);
      end
      return acted;
    endfunction

    function bit check_beat(beat_t got, output string why);
      beat_t want;
      why = "";
      beats_seen++;
      if (frames_due.size() == 0) begin
        why = $sformatf("result beat %0d (kind %0d, spi %02h) with nothing expected",
                        beats_seen, got.body.kind, got.body.spi_byte);
        return 0;
      end
      want = frames_due.pop_front();
      if (got.body.kind !== want.body.kind)
        why = {why, $sformatf(" kind %0d/%0d", got.body.kind, want.body.kind)};
      if (got.body.spi_byte !== want.body.spi_byte)
        why = {why, $sformatf(" spi_byte %02h/%02h", got.body.spi_byte, want.body.spi_byte)};
      if (got.body.deselect_after !== want.body.deselect_after)
        why = {why, $sformatf(" deselect_after %0b/%0b", got.body.deselect_after,
                              want.body.deselect_after)};
      if (got.body.host_byte !== want.body.host_byte)
        why = {why, $sformatf(" host_byte %02h/%02h", got.body.host_byte,
                              want.body.host_byte)};
      if (got.last !== want.last)
        why = {why, $sformatf(" last %0b/%0b", got.last, want.last)};
      if (why != "") begin
        why = {$sformatf("result beat %0d got/expected:", beats_seen), why};
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [15:0] cfg_wdata;

  sepw_in_if  req_ch();
  sepw_out_if res_ch();

  eeprom_frame_tracker tracker = new();

  int unsigned items_taken = 0;
  int unsigned mismatches  = 0;
  int unsigned burst_left  = 0;
  int unsigned sat_ticks   = 0;
  bit          gaps_on     = 1;
  logic [15:0] last_limit  = 16'd5;

  spi_eeprom_page_write_sequencer_core #(
    .PAGE_BYTES   (PAGE_BYTES),
    .STORAGE_BYTES(STORAGE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .request  (req_ch),
    .result   (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(string why);
    mismatches++;
    // keep the log readable if something goes badly wrong
    if (mismatches <= 50)
      $display("MISMATCH @%0t: %s", $time, why);
  endtask

  task automatic offer(input logic [2:0] cmd, input logic [15:0] addr,
                       input logic [16:0] len, input logic [7:0] db, output bit acted);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= cmd;
    req_ch.address   <= addr;
    req_ch.length    <= len;
    req_ch.data_byte <= db;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_taken++;
    acted = tracker.take_request(cmd, addr, len, db);
  endtask

  // Wait for every owed beat, then let a possibly silent last beat work through.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_poll_limit(logic [15:0] ticks);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    tracker.timeout_ticks = ticks;
    last_limit = ticks;
  endtask

  function automatic logic [15:0] addr_for(int unsigned len);
    int unsigned a;
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 511) * PAGE_BYTES + $urandom_range(100, PAGE_BYTES - 1);
      1: a = STORAGE_BYTES - len - $urandom_range(0, 2);
      default: a = $urandom_range(0, STORAGE_BYTES - 1);
    endcase
    if (a + len > STORAGE_BYTES)
      a = STORAGE_BYTES - len;
    return 16'(a);
  endfunction

  // Mostly well-formed transactions with random content, plus noise; always ends idle.
  task automatic random_traffic(int unsigned quota);
    int unsigned done_cnt, pick, a, l, r;
    logic [2:0]  c;
    logic [7:0]  b;
    bit          draining, took;
    done_cnt = 0;
    while (done_cnt < quota || tracker.phase != PH_IDLE) begin
      draining = (done_cnt >= quota);
      pick     = $urandom_range(0, 99);
      b        = 8'($urandom);
      took     = 0;
      if (!draining && pick < 12) begin
        c = 3'($urandom_range(0, 7));
        a = $urandom_range(0, STORAGE_BYTES - 1);
        // requests out of noise must never start a huge transfer
        if (c == CMD_WRITE_REQ || c == CMD_READ_REQ)
          l = $urandom_range(STORAGE_BYTES + 1 - a, 131071);
        else
          l = $urandom_range(0, 131071);
        offer(c, 16'(a), 17'(l), b, took);
      end else begin
        case (tracker.phase)
          PH_IDLE: begin
            if (pick < 20) begin
              a = $urandom_range(0, STORAGE_BYTES - 1);
              l = STORAGE_BYTES + 1 - a + $urandom_range(0, 3);
              c = $urandom_range(0, 1) ? CMD_WRITE_REQ : CMD_READ_REQ;
              offer(c, 16'(a), 17'(l), b, took);
            end else if (pick < 62) begin
              r = $urandom_range(0, 19);
              if (r == 0)
                l = 0;
              else if (r < 16)
                l = $urandom_range(1, 12);
              else if (r < 19)
                l = $urandom_range(13, 40);
              else
                l = $urandom_range(120, 260);
              offer(CMD_WRITE_REQ, addr_for(l), 17'(l), b, took);
            end else begin
              l = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
              offer(CMD_READ_REQ, addr_for(l), 17'(l), b, took);
            end
          end
          PH_WDATA:
            offer(CMD_HOST_BYTE, 16'($urandom), 17'($urandom), b, took);
          PH_POLL: begin
            if (!draining && pick < 40) begin
              offer(CMD_TICK, 16'($urandom), 17'($urandom), b, took);
            end else begin
              if (draining)
                b[0] = 1'b0;
              else
                b[0] = ($urandom_range(0, 99) < 45);
              offer(CMD_DEV_BYTE, 16'($urandom), 17'($urandom), b, took);
            end
          end
          default:
            offer(CMD_DEV_BYTE, 16'($urandom), 17'($urandom), b, took);
        endcase
      end
      if (took)
        done_cnt++;
    end
  endtask

  // Result side: check accepted beats, then pick next cycle's ready.
  initial begin
    int unsigned seg_left, mode, hold_left;
    bit          held;
    beat_t       got;
    string       why;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    held      = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.body.kind           = res_ch.kind;
        got.body.spi_byte       = res_ch.spi_byte;
        got.body.deselect_after = res_ch.deselect_after;
        got.body.host_byte      = res_ch.host_byte;
        got.last                = res_ch.last;
        if (!tracker.check_beat(got, why))
          flag_mismatch(why);
      end
      // one long hold-off so the job queue fills and request.ready drops
      if (!held && items_taken >= HOLD_AT) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ~res_ch.ready;
        endcase
      end
    end
  end

  initial begin
    bit nop;
    rst              <= 1'b1;
    cfg_wen          <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.cmd       <= CMD_TICK;
    req_ch.address   <= '0;
    req_ch.length    <= '0;
    req_ch.data_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset poll limit. Write across a page boundary, busy request ignored.
    offer(CMD_WRITE_REQ, 16'h007E, 17'd3, 8'h00, nop);
    offer(CMD_HOST_BYTE, 16'h0000, 17'd0, 8'h00, nop);
    offer(CMD_HOST_BYTE, 16'hFFFF, 17'h1FFFF, 8'hFF, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'hFE, nop);
    offer(CMD_WRITE_REQ, 16'h0000, 17'd5, 8'h00, nop);
    offer(CMD_HOST_BYTE, 16'h0000, 17'd0, 8'h5A, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'h00, nop);
    // zero lengths and range errors at the edges
    offer(CMD_WRITE_REQ, 16'hFFFF, 17'd0, 8'h00, nop);
    offer(CMD_READ_REQ, 16'h1234, 17'd0, 8'h00, nop);
    offer(CMD_WRITE_REQ, 16'hFFFF, 17'd2, 8'h00, nop);
    offer(CMD_READ_REQ, 16'h0000, 17'h1FFFF, 8'h00, nop);
    offer(CMD_WRITE_REQ, 16'h0000, 17'h10001, 8'h00, nop);
    // stray beats in idle
    offer(CMD_TICK, 16'h0000, 17'd0, 8'h00, nop);
    offer(CMD_HOST_BYTE, 16'h0000, 17'd0, 8'h11, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'h01, nop);
    offer(CMD_RSVD, 16'hFFFF, 17'h1FFFF, 8'hFF, nop);
    // last byte of storage, then a poll that runs out of ticks
    offer(CMD_WRITE_REQ, 16'hFFFF, 17'd1, 8'h00, nop);
    offer(CMD_HOST_BYTE, 16'h0000, 17'd0, 8'hA5, nop);
    repeat (5) offer(CMD_TICK, 16'h0000, 17'd0, 8'h00, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'h01, nop);
    // reads of two and one bytes
    offer(CMD_READ_REQ, 16'hFF80, 17'd2, 8'h00, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'hC3, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'h3C, nop);
    offer(CMD_READ_REQ, 16'hFFFF, 17'd1, 8'h00, nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'h81, nop);

    random_traffic(75);

    set_poll_limit(16'd1);
    random_traffic(65);

    // Widest limit: a busy status keeps polling while ticks arrive back to back.
    set_poll_limit(16'hFFFF);
    offer(CMD_WRITE_REQ, 16'($urandom), 17'd1, 8'h00, nop);
    offer(CMD_HOST_BYTE, 16'h0000, 17'd0, 8'($urandom), nop);
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'h03, nop);
    gaps_on = 0;
    repeat (8) begin
      offer(CMD_TICK, 16'h0000, 17'd0, 8'h00, nop);
      sat_ticks++;
    end
    gaps_on = 1;
    offer(CMD_DEV_BYTE, 16'h0000, 17'd0, 8'hFD, nop);
    random_traffic(40);

    set_poll_limit(16'($urandom_range(2, 20)));
    random_traffic(50);

    wait_drained();
    $display("Run covered %0d request beats (%0d ticks under the widest limit), %0d result beats",
             items_taken, sat_ticks, tracker.beats_seen);
    $display("Pages written %0d, range errors %0d, poll timeouts %0d; poll limits 5, 1, 65535, %0d",
             tracker.pages, tracker.range_errs, tracker.timeouts, last_limit);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d result beats still owed", tracker.frames_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* spi_eeprom_page_write_sequencer_core.f */
hdl/sepw_pkg.sv
hdl/sepw_if.sv
hdl/sepw_front.sv
hdl/sepw_queue.sv
hdl/sepw_back.sv
hdl/spi_eeprom_page_write_sequencer_core.sv
tb/spi_eeprom_page_write_sequencer_core_tb.sv
